// File: rtl/core/fcsp_pkg.sv
`timescale 1ns / 1ps

package fcsp_pkg;

  // Kind of a decoded result item.
  typedef enum logic [2:0] {
    KIND_ANALOG_WRITE  = 3'd0,
    KIND_PORT_WRITE    = 3'd1,
    KIND_PIN_MODE      = 3'd2,
    KIND_PIN_VALUE     = 3'd3,
    KIND_REPORT_ANALOG = 3'd4,
    KIND_REPORT_DIGIT  = 3'd5,
    KIND_SYSEX_BYTE    = 3'd6,
    KIND_SYSEX_END     = 3'd7
  } kind_t;

  // Status byte codes of the host protocol.
  localparam logic [7:0] ST_ANALOG_WRITE  = 8'hE0;
  localparam logic [7:0] ST_PORT_WRITE    = 8'h90;
  localparam logic [7:0] ST_PIN_MODE      = 8'hF4;
  localparam logic [7:0] ST_PIN_VALUE     = 8'hF5;
  localparam logic [7:0] ST_REPORT_ANALOG = 8'hC0;
  localparam logic [7:0] ST_REPORT_DIGIT  = 8'hD0;
  localparam logic [7:0] ST_SYSEX_START   = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END     = 8'hF7;
  localparam logic [7:0] ST_SYSTEM_LIMIT  = 8'hF0;

  // Record handed from the parser to the formatter.
  // For a sysex byte, d0 carries the byte itself.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  pos;
    logic        ovf;
  } cmd_rec_t;

endpackage

// File: rtl/core/fcsp_ifs.sv
`timescale 1ns / 1ps

interface fcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  channel;
  logic [6:0]  pin_number;
  logic [13:0] value;
  logic [9:0]  frequency;
  logic [7:0]  position;
  logic        overflow;

  modport source (output valid, output kind, output channel, output pin_number,
                  output value, output frequency, output position, output overflow,
                  input ready);
  modport sink   (input valid, input kind, input channel, input pin_number,
                  input value, input frequency, input position, input overflow,
                  output ready);
endinterface

// File: rtl/core/fcsp_front.sv
`timescale 1ns / 1ps

module fcsp_front #(
  parameter int SYSEX_BUFFER_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  fcsp_in_if.sink          in_ch,
  input  logic             push_ready,
  output logic             push_valid,
  output fcsp_pkg::cmd_rec_t push_rec
);

  logic       in_sysex_r, in_sysex_nxt;
  logic [1:0] awaited_r, awaited_nxt;
  logic [2:0] pending_r, pending_nxt;
  logic [3:0] chan_r, chan_nxt;
  logic [7:0] sx_count_r, sx_count_nxt;
  logic [7:0] data_r [3];
  logic [7:0] data_nxt [3];

  logic       fire;
  logic [7:0] b;
  logic [7:0] cmd;
  logic       ovf;

  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid && push_ready;
  assign b           = in_ch.rx_byte;
  assign ovf         = int'(sx_count_r) >= SYSEX_BUFFER_BYTES;

  always_comb begin
    in_sysex_nxt = in_sysex_r;
    awaited_nxt  = awaited_r;
    pending_nxt  = pending_r;
    chan_nxt     = chan_r;
    sx_count_nxt = sx_count_r;
    data_nxt     = data_r;
    cmd          = b;
    push_valid   = 1'b0;
    push_rec     = '0;

    if (in_sysex_r) begin
      if (b == fcsp_pkg::ST_SYSEX_END) begin
        in_sysex_nxt  = 1'b0;
        push_valid    = fire;
        push_rec.kind = fcsp_pkg::KIND_SYSEX_END;
        push_rec.pos  = sx_count_r;
      end else begin
        // The first few frame bytes also land in the data byte store.
        if (!ovf && sx_count_r < 8'd3) begin
          data_nxt[sx_count_r[1:0]] = b;
        end
        if (sx_count_r != 8'hFF) begin
          sx_count_nxt = sx_count_r + 8'd1;
        end
        push_valid    = fire;
        push_rec.kind = fcsp_pkg::KIND_SYSEX_BYTE;
        push_rec.d0   = b;
        push_rec.pos  = sx_count_r;
        push_rec.ovf  = ovf;
      end
    end else if (awaited_r != 2'd0 && !b[7]) begin
      // Data bytes fill from the highest slot down.
      awaited_nxt           = awaited_r - 2'd1;
      data_nxt[awaited_nxt] = b;
      if (awaited_nxt == 2'd0 && pending_r != 3'd0) begin
        pending_nxt      = 3'd0;
        push_valid       = fire;
        push_rec.kind    = fcsp_pkg::kind_t'(pending_r - 3'd1);
        push_rec.channel = chan_r;
        push_rec.d0      = data_nxt[0];
        push_rec.d1      = data_nxt[1];
        push_rec.d2      = data_nxt[2];
      end
    end else begin
      if (b < fcsp_pkg::ST_SYSTEM_LIMIT) begin
        cmd      = {b[7:4], 4'h0};
        chan_nxt = b[3:0];
      end
      unique case (cmd)
        fcsp_pkg::ST_ANALOG_WRITE: begin
          awaited_nxt = 2'd3;
          pending_nxt = 3'(fcsp_pkg::KIND_ANALOG_WRITE) + 3'd1;
        end
        fcsp_pkg::ST_PORT_WRITE: begin
          awaited_nxt = 2'd2;
          pending_nxt = 3'(fcsp_pkg::KIND_PORT_WRITE) + 3'd1;
        end
        fcsp_pkg::ST_PIN_MODE: begin
          awaited_nxt = 2'd2;
          pending_nxt = 3'(fcsp_pkg::KIND_PIN_MODE) + 3'd1;
        end
        fcsp_pkg::ST_PIN_VALUE: begin
          awaited_nxt = 2'd2;
          pending_nxt = 3'(fcsp_pkg::KIND_PIN_VALUE) + 3'd1;
        end
        fcsp_pkg::ST_REPORT_ANALOG: begin
          awaited_nxt = 2'd1;
          pending_nxt = 3'(fcsp_pkg::KIND_REPORT_ANALOG) + 3'd1;
        end
        fcsp_pkg::ST_REPORT_DIGIT: begin
          awaited_nxt = 2'd1;
          pending_nxt = 3'(fcsp_pkg::KIND_REPORT_DIGIT) + 3'd1;
        end
        fcsp_pkg::ST_SYSEX_START: begin
          in_sysex_nxt = 1'b1;
          sx_count_nxt = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r <= 1'b0;
      awaited_r  <= 2'd0;
      pending_r  <= 3'd0;
      chan_r     <= 4'd0;
      sx_count_r <= 8'd0;
    end else if (fire) begin
      in_sysex_r <= in_sysex_nxt;
      awaited_r  <= awaited_nxt;
      pending_r  <= pending_nxt;
      chan_r     <= chan_nxt;
      sx_count_r <= sx_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/core/fcsp_queue.sv
`timescale 1ns / 1ps

module fcsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fcsp_pkg::cmd_rec_t push_rec,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fcsp_pkg::cmd_rec_t pop_rec
);

  localparam int Depth = 2;

  fcsp_pkg::cmd_rec_t mem_r [Depth];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = count_r != 2'(Depth);
  assign pop_valid  = count_r != 2'd0;
  assign pop_rec    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: rtl/core/fcsp_back.sv
`timescale 1ns / 1ps

module fcsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  fcsp_pkg::cmd_rec_t pop_rec,
  fcsp_out_if.source         out_ch
);

  logic        valid_r;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [6:0]  pin_r, pin_nxt;
  logic [13:0] value_r, value_nxt;
  logic [9:0]  freq_r, freq_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        ovf_r, ovf_nxt;
  logic [14:0] port_sum;

  assign pop_ready = !valid_r || out_ch.ready;
  assign port_sum  = {pop_rec.d0, 7'b0} + {7'b0, pop_rec.d1};

  always_comb begin
    kind_nxt  = 3'(pop_rec.kind);
    chan_nxt  = 4'd0;
    pin_nxt   = 7'd0;
    value_nxt = 14'd0;
    freq_nxt  = 10'd0;
    pos_nxt   = 8'd0;
    ovf_nxt   = 1'b0;
    unique case (pop_rec.kind)
      fcsp_pkg::KIND_ANALOG_WRITE: begin
        chan_nxt  = pop_rec.channel;
        value_nxt = {7'b0, pop_rec.d2[6:0]};
        freq_nxt  = {pop_rec.d1[2:0], pop_rec.d0[6:0]};
      end
      fcsp_pkg::KIND_PORT_WRITE: begin
        chan_nxt  = pop_rec.channel;
        value_nxt = port_sum[13:0];
      end
      fcsp_pkg::KIND_PIN_MODE, fcsp_pkg::KIND_PIN_VALUE: begin
        pin_nxt   = pop_rec.d1[6:0];
        value_nxt = {6'b0, pop_rec.d0};
      end
      fcsp_pkg::KIND_REPORT_ANALOG, fcsp_pkg::KIND_REPORT_DIGIT: begin
        chan_nxt  = pop_rec.channel;
        value_nxt = {6'b0, pop_rec.d0};
      end
      fcsp_pkg::KIND_SYSEX_BYTE: begin
        value_nxt = {6'b0, pop_rec.d0};
        pos_nxt   = pop_rec.pos;
        ovf_nxt   = pop_rec.ovf;
      end
      fcsp_pkg::KIND_SYSEX_END: begin
        pos_nxt = pop_rec.pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      kind_r  <= kind_nxt;
      chan_r  <= chan_nxt;
      pin_r   <= pin_nxt;
      value_r <= value_nxt;
      freq_r  <= freq_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.channel    = chan_r;
  assign out_ch.pin_number = pin_r;
  assign out_ch.value      = value_r;
  assign out_ch.frequency  = freq_r;
  assign out_ch.position   = pos_r;
  assign out_ch.overflow   = ovf_r;

endmodule

// File: rtl/core/firmata_command_stream_parser_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   rx_byte[7:0]
// out_ch    out  valid/ready   kind, channel, pin_number, value, frequency,
//                              position, overflow
//
// One received byte is taken every cycle while the two-entry command queue
// has room; the parser settles each byte in the cycle it is accepted.
// A decoded command is written into the queue when its last byte is taken,
// then into the formatting register, one per cycle unless out_ch stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled out_ch fills the queue, and only then is in_ch.ready dropped.
module firmata_command_stream_parser_unit #(
  parameter int SYSEX_BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fcsp_in_if.sink    in_ch,
  fcsp_out_if.source out_ch
);

  // The front parses status and data bytes and tracks sysex frames. It pushes
  // one record into the queue for every byte that completes a result.
  logic               push_valid;
  logic               push_ready;
  fcsp_pkg::cmd_rec_t push_rec;

  // The back pops records and formats the result fields into the output
  // register, which it holds until the sink takes the item.
  logic               pop_valid;
  logic               pop_ready;
  fcsp_pkg::cmd_rec_t pop_rec;

  fcsp_front #(
    .SYSEX_BUFFER_BYTES(SYSEX_BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_rec   (push_rec)
  );

  fcsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  fcsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_ch    (out_ch)
  );

  // Reset leaves no result item pending at the output.
  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result item valid right after reset");

  // The parser must never push a record while the queue is full.
  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("command record pushed into a full queue");

  // Only a sysex byte can carry the overflow flag.
  a_overflow_kind : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |->
      (out_ch.kind == 3'(fcsp_pkg::KIND_SYSEX_BYTE)))
    else $error("overflow flag set on a non-sysex item");

  // Only analog write carries a frequency.
  a_frequency_kind : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frequency != 10'd0) |->
      (out_ch.kind == 3'(fcsp_pkg::KIND_ANALOG_WRITE)))
    else $error("frequency set on an item other than analog write");

endmodule
